// ===== hdl/lzx_pkg.sv =====
`timescale 1ns / 1ps

package lzx_pkg;

    // History ring geometry.
    localparam int HIST_DEPTH = 256;
    localparam int HIST_AW    = $clog2(HIST_DEPTH);
    localparam int HIST_LW    = $clog2(HIST_DEPTH) + 1;

    // Run length counter width and match length bias.
    localparam int REM_W = 15;
    localparam logic [REM_W-1:0] MATCH_BIAS = REM_W'(4);

    // Input item modes.
    localparam logic MODE_BYTE = 1'b0;
    localparam logic MODE_STEP = 1'b1;

    // One input transaction.
    typedef struct packed {
        logic       mode;
        logic [7:0] data_byte;
    } lzx_in_t;

    // One result transaction.
    typedef struct packed {
        logic [7:0] out_byte;
        logic       last_of_run;
        logic       copy_pending;
        logic       is_error;
    } lzx_out_t;

    // Command from the decoder to the ring stage for one accepted item.
    typedef struct packed {
        logic               has_result;
        logic               use_ring;
        logic               wr_en;
        logic [HIST_AW-1:0] waddr;
        logic [HIST_AW-1:0] raddr;
        logic [7:0]         lit_byte;
        logic               last;
        logic               pend;
        logic               err;
    } lzx_cmd_t;

endpackage

// ===== hdl/lz_stream_expander_top.sv =====
`timescale 1ns / 1ps

// Streaming LZ decoder with a 256-byte history ring. Each input transaction is
// either a compressed byte (mode 0) or a step (mode 1) that pulls one byte of a
// pending match copy; each gives at most one result transaction. The block takes
// one transaction per cycle while the output is not stalled, and a result passes
// through the synchronous ring read stage and then the output register. The ring
// has one write and one read port; a copy at distance one is served by forwarding
// the byte written in the same cycle. Ring entries are not cleared at reset; the
// distance check keeps unwritten entries from being read. Errors (distance beyond
// history seen, or a compressed byte during a copy) are sticky until reset.
module lz_stream_expander_top
    import lzx_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     in_valid,
    output logic     in_ready,
    input  lzx_in_t  in_data,
    output logic     out_valid,
    input  logic     out_ready,
    output lzx_out_t out_data
);

    logic     accept;
    logic     take;
    logic     res_valid;
    lzx_cmd_t cmd;
    lzx_out_t res;

    assign accept = in_valid && in_ready;

    // Header, length and offset decode with run bookkeeping.
    lzx_ctrl u_ctrl (
        .clk     (clk),
        .rst_n   (rst_n),
        .accept  (accept),
        .in_data (in_data),
        .cmd     (cmd)
    );

    // History ring and read stage.
    lzx_ring u_ring (
        .clk       (clk),
        .rst_n     (rst_n),
        .accept    (accept),
        .cmd       (cmd),
        .take      (take),
        .ready     (in_ready),
        .res_valid (res_valid),
        .res       (res)
    );

    // Output register.
    lzx_out u_out (
        .clk       (clk),
        .rst_n     (rst_n),
        .res_valid (res_valid),
        .res       (res),
        .take      (take),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

endmodule

// ===== hdl/lzx_ctrl.sv =====
`timescale 1ns / 1ps

module lzx_ctrl
    import lzx_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     accept,
    input  lzx_in_t  in_data,
    output lzx_cmd_t cmd
);

    typedef enum logic [2:0] {
        PH_HEADER,
        PH_LEN_LOW,
        PH_OFFSET,
        PH_COPY,
        PH_LITERAL,
        PH_ERROR
    } phase_t;

    phase_t             phase_reg, phase_next;
    logic [REM_W-1:0]   rem_reg, rem_next;
    logic [HIST_AW-1:0] wr_pos_reg, wr_pos_next;
    logic [HIST_AW-1:0] rd_pos_reg, rd_pos_next;
    logic [HIST_LW-1:0] hist_len_reg, hist_len_next;

    logic [REM_W-1:0]   rem_dec;
    logic [REM_W:0]     grow_sum;
    logic [HIST_LW-1:0] grown_len;
    logic [HIST_LW-1:0] match_dist;
    logic [REM_W-1:0]   lit_len;

    // Count of bytes left after this one, and history growth by the current run.
    assign rem_dec    = rem_reg - REM_W'(1);
    assign lit_len    = REM_W'(in_data.data_byte) + REM_W'(1);
    assign match_dist = HIST_LW'(in_data.data_byte) + HIST_LW'(1);

    always_comb
    begin
        logic [REM_W-1:0] grow_by;
        grow_by  = (phase_reg == PH_HEADER) ? lit_len : rem_reg;
        grow_sum = (REM_W+1)'(hist_len_reg) + (REM_W+1)'(grow_by);
        if (grow_sum > (REM_W+1)'(HIST_DEPTH))
            grown_len = HIST_LW'(HIST_DEPTH);
        else
            grown_len = grow_sum[HIST_LW-1:0];
    end

    // Decode one item: next control state and the command for the ring stage.
    always_comb
    begin
        phase_next    = phase_reg;
        rem_next      = rem_reg;
        wr_pos_next   = wr_pos_reg;
        rd_pos_next   = rd_pos_reg;
        hist_len_next = hist_len_reg;

        cmd            = '0;
        cmd.waddr      = wr_pos_reg;
        cmd.raddr      = rd_pos_reg;
        cmd.lit_byte   = in_data.data_byte;

        if (phase_reg == PH_ERROR)
        begin
            cmd.has_result = 1'b1;
            cmd.err        = 1'b1;
        end
        else if (in_data.mode == MODE_STEP)
        begin
            // A step only moves a pending copy forward.
            if (phase_reg == PH_COPY)
            begin
                cmd.has_result = 1'b1;
                cmd.use_ring   = 1'b1;
                cmd.wr_en      = 1'b1;
                rd_pos_next    = rd_pos_reg + HIST_AW'(1);
                wr_pos_next    = wr_pos_reg + HIST_AW'(1);
                rem_next       = rem_dec;
                if (rem_dec == '0)
                begin
                    cmd.last   = 1'b1;
                    phase_next = PH_HEADER;
                end
                else
                begin
                    cmd.pend = 1'b1;
                end
            end
        end
        else
        begin
            unique case (phase_reg)
                PH_HEADER:
                begin
                    if (!in_data.data_byte[7])
                    begin
                        rem_next      = lit_len;
                        hist_len_next = grown_len;
                        phase_next    = PH_LITERAL;
                    end
                    else if (in_data.data_byte[6])
                    begin
                        rem_next   = REM_W'(in_data.data_byte[6:0]);
                        phase_next = PH_LEN_LOW;
                    end
                    else
                    begin
                        rem_next   = REM_W'(in_data.data_byte[5:0]) + MATCH_BIAS;
                        phase_next = PH_OFFSET;
                    end
                end
                PH_LEN_LOW:
                begin
                    rem_next   = REM_W'({rem_reg[5:0], in_data.data_byte}) + MATCH_BIAS;
                    phase_next = PH_OFFSET;
                end
                PH_OFFSET:
                begin
                    if (match_dist > hist_len_reg)
                    begin
                        cmd.has_result = 1'b1;
                        cmd.err        = 1'b1;
                        phase_next     = PH_ERROR;
                    end
                    else
                    begin
                        rd_pos_next   = wr_pos_reg + ~in_data.data_byte;
                        hist_len_next = grown_len;
                        phase_next    = PH_COPY;
                    end
                end
                PH_LITERAL:
                begin
                    cmd.has_result = 1'b1;
                    cmd.wr_en      = 1'b1;
                    wr_pos_next    = wr_pos_reg + HIST_AW'(1);
                    rem_next       = rem_dec;
                    if (rem_dec == '0)
                    begin
                        cmd.last   = 1'b1;
                        phase_next = PH_HEADER;
                    end
                end
                default:
                begin
                    // A compressed byte while a copy is pending.
                    cmd.has_result = 1'b1;
                    cmd.err        = 1'b1;
                    phase_next     = PH_ERROR;
                end
            endcase
        end

        // An error result carries nothing else.
        if (cmd.err)
            cmd.lit_byte = '0;
    end

    // Decoder state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg    <= PH_HEADER;
            rem_reg      <= '0;
            wr_pos_reg   <= '0;
            rd_pos_reg   <= '0;
            hist_len_reg <= '0;
        end
        else if (accept)
        begin
            phase_reg    <= phase_next;
            rem_reg      <= rem_next;
            wr_pos_reg   <= wr_pos_next;
            rd_pos_reg   <= rd_pos_next;
            hist_len_reg <= hist_len_next;
        end
    end

endmodule

// ===== hdl/lzx_ring.sv =====
`timescale 1ns / 1ps

module lzx_ring
    import lzx_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     accept,
    input  lzx_cmd_t cmd,
    input  logic     take,
    output logic     ready,
    output logic     res_valid,
    output lzx_out_t res
);

    logic [7:0]  ring [HIST_DEPTH];
    logic [7:0]  rdata_reg;
    logic        fwd_reg, fwd_next;
    logic [7:0]  fwd_byte_reg;
    lzx_cmd_t    s1_cmd_reg;
    logic        s1_valid_reg, s1_valid_next;

    logic        adv;
    logic        wr_fire;
    logic [7:0]  s1_byte;

    // The read stage moves on whenever the output register can take its result.
    assign adv     = s1_valid_reg && take;
    assign ready   = !s1_valid_reg || take;
    assign wr_fire = adv && s1_cmd_reg.wr_en;

    // A copy byte comes from the ring, or from the write that landed with its read.
    always_comb
    begin
        if (!s1_cmd_reg.use_ring)
            s1_byte = s1_cmd_reg.lit_byte;
        else if (fwd_reg)
            s1_byte = fwd_byte_reg;
        else
            s1_byte = rdata_reg;
    end

    // A read at distance one meets the previous byte's write at the same edge.
    assign fwd_next = wr_fire && (s1_cmd_reg.waddr == cmd.raddr);

    assign s1_valid_next = accept ? 1'b1 : (adv ? 1'b0 : s1_valid_reg);

    // Result of the read stage.
    assign res_valid        = adv && s1_cmd_reg.has_result;
    assign res.out_byte     = s1_byte;
    assign res.last_of_run  = s1_cmd_reg.last;
    assign res.copy_pending = s1_cmd_reg.pend;
    assign res.is_error     = s1_cmd_reg.err;

    // History ring write port.
    always_ff @(posedge clk)
    begin
        if (wr_fire)
            ring[s1_cmd_reg.waddr] <= s1_byte;
    end

    // History ring read port and read stage payload.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            rdata_reg    <= ring[cmd.raddr];
            fwd_byte_reg <= s1_byte;
            s1_cmd_reg   <= cmd;
        end
    end

    // Read stage control.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            fwd_reg      <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= s1_valid_next;
            if (accept)
                fwd_reg <= fwd_next;
        end
    end

endmodule

// ===== hdl/lzx_out.sv =====
`timescale 1ns / 1ps

module lzx_out
    import lzx_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     res_valid,
    input  lzx_out_t res,
    output logic     take,
    output logic     out_valid,
    input  logic     out_ready,
    output lzx_out_t out_data
);

    logic     out_valid_reg, out_valid_next;
    lzx_out_t out_data_reg;

    // The register takes a new result when empty or being drained.
    assign take           = !out_valid_reg || out_ready;
    assign out_valid_next = take ? res_valid : out_valid_reg;

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    // Output payload.
    always_ff @(posedge clk)
    begin
        if (take && res_valid)
            out_data_reg <= res;
    end

    // Output valid.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else
            out_valid_reg <= out_valid_next;
    end

endmodule
